// ===== hw/rtl/ffba_pkg.sv =====
package ffba_pkg;

   localparam int MAX_BLOCKS  = 64;
   localparam int IDX_W       = 6;   // block index
   localparam int CNT_W       = 7;   // block counts 0..MAX_BLOCKS
   localparam int BYTES_W     = 15;
   localparam int BYTE_SHIFT  = 8;   // 256-byte blocks
   localparam int NEED_W      = BYTES_W - BYTE_SHIFT + 1;
   localparam int MAX_RESULTS = 32;
   localparam int RES_IDX_W   = 5;
   localparam int RES_CNT_W   = 6;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic               command;
      logic [BYTES_W-1:0] file_bytes;
      logic [IDX_W-1:0]   run_start;
      logic [CNT_W-1:0]   run_length;
   } ffba_req_type;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] chunk_start;
      logic [CNT_W-1:0] chunk_length;
      logic             last;
      logic [CNT_W-1:0] free_left;
   } ffba_rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [CNT_W-1:0] length;
   } ffba_chunk_type;

   // bitmap write port from the sequencer, one block per cycle
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic             wr_used;
   } ffba_map_ctl_type;

endpackage

// ===== hw/rtl/ffba_bitmap.sv =====
module ffba_bitmap (
   input  logic                       clock,
   input  ffba_pkg::ffba_map_ctl_type ctl,
   input  logic [ffba_pkg::IDX_W-1:0] rd_idx,
   output logic                       rd_used
);
   import ffba_pkg::*;

   logic used_mem [MAX_BLOCKS];
   logic rd_used_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         used_mem[ctl.wr_idx] <= ctl.wr_used;
      end
      rd_used_ff <= used_mem[rd_idx];
   end

   assign rd_used = rd_used_ff;

endmodule

// ===== hw/rtl/ffba_chunk_buf.sv =====
module ffba_chunk_buf (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ffba_pkg::RES_IDX_W-1:0] wr_addr,
   input  ffba_pkg::ffba_chunk_type       wr_data,
   input  logic [ffba_pkg::RES_IDX_W-1:0] rd_addr,
   output ffba_pkg::ffba_chunk_type       rd_data
);
   import ffba_pkg::*;

   ffba_chunk_type mem [MAX_RESULTS];
   ffba_chunk_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/first_fit_block_allocator_core.sv =====
// Allocate: scans one block per cycle up to the last block taken, the store end or the chunk
// limit, then a count/commit pass over the N live blocks (N = live block count), then one
// response per chunk. Free: the count/commit pass, then one response. No space: the scan and
// the count pass, then one response. One request at a time; the next is taken in the cycle
// the last response is out.
// Reset (synchronous): clearing pass with busy high, all blocks free, block count 64.
module first_fit_block_allocator_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ffba_pkg::ffba_req_type       req_data,
   output logic                         rsp_valid,
   output ffba_pkg::ffba_rsp_type       rsp_data,
   input  logic                         csr_we,
   input  logic [ffba_pkg::CNT_W-1:0]   csr_wdata
);
   import ffba_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ALLOC = 3'd1;
   localparam logic [2:0] ST_CLEAR = 3'd2;
   localparam logic [2:0] ST_COUNT = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     blocks_ff;        // block count register
   logic [CNT_W-1:0]     pos_ff, pos_in;   // shared block index
   logic [CNT_W-1:0]     lo_ff, lo_in;     // write-back region [lo, hi)
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic                 mark_ff, mark_in; // value written over the region
   logic [NEED_W-1:0]    need_ff, need_in;
   logic                 in_run_ff, in_run_in;
   logic [IDX_W-1:0]     cstart_ff, cstart_in;
   logic [CNT_W-1:0]     clen_ff, clen_in;
   logic [RES_CNT_W-1:0] chunks_ff, chunks_in;
   logic                 fail_ff, fail_in;
   logic                 single_ff, single_in;  // free or failed alloc: one response
   logic [CNT_W-1:0]     cnt_ff, cnt_in;        // free-block count
   logic [RES_IDX_W-1:0] emit_ff, emit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffba_rsp_type         rsp_ff, rsp_in;

   ffba_map_ctl_type     map_ctl;
   logic                 map_used;
   logic                 cbuf_we;
   ffba_chunk_type       cbuf_wdata;
   logic [RES_IDX_W-1:0] cbuf_raddr;
   ffba_chunk_type       cbuf_rdata;

   logic [CNT_W-1:0]     live_n;
   logic [CNT_W-1:0]     pos_inc;
   logic [NEED_W-1:0]    need_req;
   logic [CNT_W:0]       free_sum;
   logic [CNT_W-1:0]     free_end;
   logic [IDX_W-1:0]     run_s;
   logic [CNT_W-1:0]     run_l;
   logic                 in_region;
   logic                 blk_used;

   // bitmap read is registered: the address is the next index, so the
   // data in a cycle always belongs to pos_ff
   ffba_bitmap u_bitmap (
      .clock   (clock),
      .ctl     (map_ctl),
      .rd_idx  (pos_in[IDX_W-1:0]),
      .rd_used (map_used)
   );

   ffba_chunk_buf u_chunk_buf (
      .clock   (clock),
      .wr_en   (cbuf_we),
      .wr_addr (chunks_ff[RES_IDX_W-1:0]),
      .wr_data (cbuf_wdata),
      .rd_addr (cbuf_raddr),
      .rd_data (cbuf_rdata)
   );

   // effective block count: 0 acts as 1, above the store size clamps
   always_comb begin
      if (blocks_ff == '0) begin
         live_n = CNT_W'(1);
      end else if (blocks_ff > CNT_W'(MAX_BLOCKS)) begin
         live_n = CNT_W'(MAX_BLOCKS);
      end else begin
         live_n = blocks_ff;
      end
   end

   // blocks needed: ceil(bytes / 256), at least one
   always_comb begin
      need_req = NEED_W'(req_data.file_bytes >> BYTE_SHIFT)
               + NEED_W'(|req_data.file_bytes[BYTE_SHIFT-1:0]);
      if (need_req == '0) begin
         need_req = NEED_W'(1);
      end
   end

   // free run clamped to the live blocks
   always_comb begin
      free_sum = (CNT_W+1)'(req_data.run_start) + (CNT_W+1)'(req_data.run_length);
      if (free_sum > (CNT_W+1)'(live_n)) begin
         free_end = live_n;
      end else begin
         free_end = free_sum[CNT_W-1:0];
      end
   end

   assign pos_inc = pos_ff + CNT_W'(1);
   assign run_s   = in_run_ff ? cstart_ff : pos_ff[IDX_W-1:0];
   assign run_l   = in_run_ff ? clen_ff + CNT_W'(1) : CNT_W'(1);

   // count pass: blocks inside the write-back region take the new value
   assign in_region = (pos_ff >= lo_ff) && (pos_ff < hi_ff);
   assign blk_used  = in_region ? mark_ff : map_used;

   // chunk buffer read runs one ahead of the emit index
   assign cbuf_raddr = (state_ff == ST_EMIT) ? emit_ff + RES_IDX_W'(1) : '0;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mark_in      = mark_ff;
      need_in      = need_ff;
      in_run_in    = in_run_ff;
      cstart_in    = cstart_ff;
      clen_in      = clen_ff;
      chunks_in    = chunks_ff;
      fail_in      = fail_ff;
      single_in    = single_ff;
      cnt_in       = cnt_ff;
      emit_in      = emit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_ctl      = '0;
      cbuf_we      = 1'b0;
      cbuf_wdata   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // after reset: mark every block free, one per cycle
            map_ctl.wr_en   = 1'b1;
            map_ctl.wr_idx  = pos_ff[IDX_W-1:0];
            map_ctl.wr_used = 1'b0;
            pos_in          = pos_inc;
            if (pos_inc == CNT_W'(MAX_BLOCKS)) begin
               state_in = ST_IDLE;
               pos_in   = '0;
            end
         end

         ST_IDLE: begin
            if (start) begin
               fail_in   = 1'b0;
               chunks_in = '0;
               in_run_in = 1'b0;
               cnt_in    = '0;
               pos_in    = '0;
               if (req_data.command == CMD_FREE) begin
                  // the run is cleared during the count pass; empty if start >= end
                  single_in = 1'b1;
                  lo_in     = CNT_W'(req_data.run_start);
                  hi_in     = free_end;
                  mark_in   = 1'b0;
                  state_in  = ST_COUNT;
               end else begin
                  single_in = 1'b0;
                  need_in   = need_req;
                  state_in  = ST_ALLOC;
               end
            end
         end

         ST_ALLOC: begin
            pos_in = pos_inc;
            if (!map_used) begin
               if (!in_run_ff && (chunks_ff == RES_CNT_W'(MAX_RESULTS))) begin
                  // a new chunk would exceed the response limit
                  fail_in = 1'b1;
               end else begin
                  in_run_in = 1'b1;
                  cstart_in = run_s;
                  clen_in   = run_l;
                  need_in   = need_ff - NEED_W'(1);
                  if (need_ff == NEED_W'(1)) begin
                     // every block below pos_inc is now taken
                     cbuf_we           = 1'b1;
                     cbuf_wdata.start  = run_s;
                     cbuf_wdata.length = run_l;
                     chunks_in         = chunks_ff + RES_CNT_W'(1);
                     lo_in             = '0;
                     hi_in             = pos_inc;
                     mark_in           = 1'b1;
                     state_in          = ST_COUNT;
                     pos_in            = '0;
                  end else if (pos_inc == live_n) begin
                     fail_in = 1'b1;
                  end
               end
            end else begin
               if (in_run_ff) begin
                  cbuf_we           = 1'b1;
                  cbuf_wdata.start  = cstart_ff;
                  cbuf_wdata.length = clen_ff;
                  chunks_in         = chunks_ff + RES_CNT_W'(1);
                  in_run_in         = 1'b0;
               end
               if (pos_inc == live_n) begin
                  fail_in = 1'b1;
               end
            end
            if (fail_in) begin
               // empty write-back region: the map is left untouched
               single_in = 1'b1;
               lo_in     = '0;
               hi_in     = '0;
               state_in  = ST_COUNT;
               pos_in    = '0;
            end
         end

         ST_COUNT: begin
            if (in_region) begin
               map_ctl.wr_en   = 1'b1;
               map_ctl.wr_idx  = pos_ff[IDX_W-1:0];
               map_ctl.wr_used = mark_ff;
            end
            cnt_in = cnt_ff + CNT_W'(!blk_used);
            pos_in = pos_inc;
            if (pos_inc == live_n) begin
               if (single_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = fail_ff ? STATUS_NO_SPACE : STATUS_OK;
                  rsp_in.chunk_start  = '0;
                  rsp_in.chunk_length = '0;
                  rsp_in.last         = 1'b1;
                  rsp_in.free_left    = cnt_in;
                  state_in            = ST_IDLE;
               end else begin
                  emit_in  = '0;
                  state_in = ST_EMIT;
               end
            end
         end

         ST_EMIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.chunk_start  = cbuf_rdata.start;
            rsp_in.chunk_length = cbuf_rdata.length;
            rsp_in.last         = (RES_CNT_W'(emit_ff) + RES_CNT_W'(1)) == chunks_ff;
            rsp_in.free_left    = cnt_ff;
            emit_in             = emit_ff + RES_IDX_W'(1);
            if (rsp_in.last) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         blocks_ff    <= CNT_W'(MAX_BLOCKS);
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         chunks_ff    <= '0;
         in_run_ff    <= 1'b0;
         fail_ff      <= 1'b0;
         single_ff    <= 1'b0;
         emit_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         chunks_ff    <= chunks_in;
         in_run_ff    <= in_run_in;
         fail_ff      <= fail_in;
         single_ff    <= single_in;
         emit_ff      <= emit_in;
         if (csr_we) begin
            blocks_ff <= csr_wdata;
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mark_ff   <= mark_in;
      need_ff   <= need_in;
      cstart_ff <= cstart_in;
      clen_ff   <= clen_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
